// ===== hw/rtl/scl_pkg.sv =====
// shared constants, codes and types of the serial command line parser
`timescale 1ns / 1ps

package scl_pkg;

  // line buffer and field store geometry
  localparam int LINE_BYTES = 64;
  localparam int MAX_FIELDS = 8;

  localparam int LINE_AW  = $clog2(LINE_BYTES);
  localparam int CNT_W    = $clog2(LINE_BYTES + 1);
  localparam int FIELD_AW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
  localparam int FCNT_W   = $clog2(MAX_FIELDS + 1);
  localparam int IDX_W    = (LINE_AW > FIELD_AW) ? LINE_AW : FIELD_AW;

  // payload widths
  localparam int BYTE_W = 8;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 7;
  localparam int KIND_W = 2;

  // character codes
  localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
  localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_NAME     = 2'd0,
    KIND_FIELD    = 2'd1,
    KIND_OVERFLOW = 2'd2
  } kind_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_READ,
    ST_LOAD,
    ST_WAIT
  } state_e;

  // field parse phases
  typedef enum logic [1:0] {
    PH_SKIP,
    PH_DIGITS,
    PH_IGNORE
  } phase_e;

  // command from the sequencer to the field unit
  typedef struct packed {
    logic              feed;
    logic              clear;
    logic [BYTE_W-1:0] data;
  } field_cmd_t;

endpackage

// ===== hw/rtl/scl_stream_if.sv =====
// valid/ready channel interfaces for received bytes and parser results
`timescale 1ns / 1ps

interface scl_rx_if import scl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface scl_res_if import scl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       kind;
  logic [BYTE_W-1:0]       name_char;
  logic signed [VAL_W-1:0] field_value;
  logic [POS_W-1:0]        position;
  logic                    last;

  modport source (output valid, output kind, output name_char, output field_value,
                  output position, output last, input ready);
  modport sink (input valid, input kind, input name_char, input field_value,
                input position, input last, output ready);
endinterface

// ===== hw/rtl/scl_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module scl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/scl_field_unit.sv =====
// atoi style field accumulator with a shift-add multiply by ten
`timescale 1ns / 1ps

module scl_field_unit import scl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  field_cmd_t       cmd_i,
  output logic [VAL_W-1:0] value_o
);

  phase_e           phase_q, phase_d;
  logic             neg_q, neg_d;
  logic [VAL_W-1:0] acc_q, acc_d;

  logic             is_ws;
  logic             is_sign;
  logic             is_digit;
  logic [BYTE_W-1:0] digit_val;
  logic [VAL_W-1:0] acc_times_ten;

  // byte classes
  always_comb begin
    is_ws    = (cmd_i.data == CH_SPACE) || (cmd_i.data == CH_TAB) ||
               (cmd_i.data == CH_VT) || (cmd_i.data == CH_FF) ||
               (cmd_i.data == CH_CR);
    is_sign  = (cmd_i.data == CH_PLUS) || (cmd_i.data == CH_MINUS);
    is_digit = (cmd_i.data >= CH_ZERO) && (cmd_i.data <= CH_NINE);
    digit_val = cmd_i.data - CH_ZERO;
  end

  // acc * 10 as two shifts and an add, wrapping at 32 bits
  assign acc_times_ten = (acc_q << 3) + (acc_q << 1);

  // next parse state
  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    if (cmd_i.clear) begin
      phase_d = PH_SKIP;
      neg_d   = 1'b0;
      acc_d   = '0;
    end else if (cmd_i.feed) begin
      if ((phase_q == PH_SKIP) && is_ws) begin
        phase_d = PH_SKIP;
      end else if ((phase_q == PH_SKIP) && is_sign) begin
        neg_d   = (cmd_i.data == CH_MINUS);
        phase_d = PH_DIGITS;
      end else if ((phase_q != PH_IGNORE) && is_digit) begin
        acc_d   = acc_times_ten + VAL_W'(digit_val[3:0]);
        phase_d = PH_DIGITS;
      end else begin
        phase_d = PH_IGNORE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SKIP;
      neg_q   <= 1'b0;
      acc_q   <= '0;
    end else begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      acc_q   <= acc_d;
    end
  end

  // signed value of the field closed now
  assign value_o = neg_q ? (~acc_q + VAL_W'(1)) : acc_q;

endmodule

// ===== hw/rtl/scl_ctrl.sv =====
// line sequencer: byte intake, name and field runs, output register
`timescale 1ns / 1ps

module scl_ctrl import scl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  scl_rx_if.sink              rx_i,
  scl_res_if.source           res_o,
  output field_cmd_t          field_cmd_o,
  output logic                line_we_o,
  output logic [LINE_AW-1:0]  line_waddr_o,
  output logic [BYTE_W-1:0]   line_wdata_o,
  output logic [LINE_AW-1:0]  line_raddr_o,
  input  logic [BYTE_W-1:0]   line_rdata_i,
  output logic                fld_we_o,
  output logic [FIELD_AW-1:0] fld_waddr_o,
  output logic [FIELD_AW-1:0] fld_raddr_o,
  input  logic [VAL_W-1:0]    fld_rdata_i
);

  state_e            state_q, state_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              name_taken_q, name_taken_d;
  logic [FCNT_W-1:0] fcount_q, fcount_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              run_name_q, run_name_d;

  logic              out_valid_q, out_valid_d;
  kind_e             out_kind_q, out_kind_d;
  logic [BYTE_W-1:0] out_char_q, out_char_d;
  logic [VAL_W-1:0]  out_val_q, out_val_d;
  logic [POS_W-1:0]  out_pos_q, out_pos_d;
  logic              out_last_q, out_last_d;

  logic rx_fire;
  logic res_fire;
  logic is_full;
  logic is_colon;
  logic is_nl;
  logic is_sep;
  logic take_name;
  logic fields_open;
  logic name_last;
  logic field_last;

  // byte decode
  always_comb begin
    rx_fire     = rx_i.valid && rx_i.ready;
    res_fire    = res_o.valid && res_o.ready;
    is_full     = (count_q == CNT_W'(LINE_BYTES));
    is_colon    = (byte_q == CH_COLON);
    is_nl       = (byte_q == CH_NL);
    is_sep      = is_colon || is_nl || (byte_q == CH_SEMI);
    take_name   = is_colon && !name_taken_q && (count_q != '0);
    fields_open = (fcount_q < FCNT_W'(MAX_FIELDS));
    name_last   = ((CNT_W'(idx_q) + CNT_W'(2)) == count_q);
    field_last  = ((FCNT_W'(idx_q) + FCNT_W'(1)) == fcount_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (rx_fire) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (is_full) state_d = ST_WAIT;
        else if (take_name || (is_sep && is_nl)) state_d = ST_READ;
        else state_d = ST_IDLE;
      end
      ST_READ: state_d = ST_LOAD;
      ST_LOAD: state_d = ST_WAIT;
      ST_WAIT: begin
        if (res_fire) state_d = out_last_q ? ST_IDLE : ST_READ;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs and strobes
  always_comb begin
    rx_i.ready         = (state_q == ST_IDLE);
    line_we_o          = 1'b0;
    fld_we_o           = 1'b0;
    field_cmd_o.feed   = 1'b0;
    field_cmd_o.clear  = 1'b0;
    field_cmd_o.data   = byte_q;
    unique case (state_q)
      ST_IDLE: begin
        line_we_o = rx_fire && !is_full;
      end
      ST_DECIDE: begin
        if (is_full || take_name) begin
          field_cmd_o.clear = 1'b1;
        end else if (is_sep) begin
          field_cmd_o.clear = 1'b1;
          fld_we_o          = fields_open;
        end else begin
          field_cmd_o.feed = 1'b1;
        end
      end
      ST_READ, ST_LOAD, ST_WAIT: begin
        line_we_o = 1'b0;
      end
      default: begin
        line_we_o = 1'b0;
      end
    endcase
  end

  // store addresses
  assign line_waddr_o = count_q[LINE_AW-1:0];
  assign line_wdata_o = rx_i.rx_byte;
  assign line_raddr_o = idx_q[LINE_AW-1:0];
  assign fld_waddr_o  = fcount_q[FIELD_AW-1:0];
  assign fld_raddr_o  = idx_q[FIELD_AW-1:0];

  // line bookkeeping and output register
  always_comb begin
    byte_d       = byte_q;
    count_d      = count_q;
    name_taken_d = name_taken_q;
    fcount_d     = fcount_q;
    idx_d        = idx_q;
    run_name_d   = run_name_q;
    out_valid_d  = out_valid_q;
    out_kind_d   = out_kind_q;
    out_char_d   = out_char_q;
    out_val_d    = out_val_q;
    out_pos_d    = out_pos_q;
    out_last_d   = out_last_q;

    if (rx_fire) byte_d = rx_i.rx_byte;

    if (state_q == ST_DECIDE) begin
      if (is_full) begin
        // line overflow: drop the byte and start over
        count_d      = '0;
        name_taken_d = 1'b0;
        fcount_d     = '0;
        out_valid_d  = 1'b1;
        out_kind_d   = KIND_OVERFLOW;
        out_char_d   = '0;
        out_val_d    = '0;
        out_pos_d    = POS_W'(count_q);
        out_last_d   = 1'b1;
      end else begin
        count_d = count_q + CNT_W'(1);
        if (take_name) begin
          name_taken_d = 1'b1;
          fcount_d     = '0;
          idx_d        = '0;
          run_name_d   = 1'b1;
        end else if (is_sep) begin
          if (fields_open) fcount_d = fcount_q + FCNT_W'(1);
          if (is_nl) begin
            idx_d      = '0;
            run_name_d = 1'b0;
          end
        end
      end
    end

    // load one result from the registered store read
    if (state_q == ST_LOAD) begin
      out_valid_d = 1'b1;
      out_pos_d   = POS_W'(idx_q);
      if (run_name_q) begin
        out_kind_d = KIND_NAME;
        out_char_d = line_rdata_i;
        out_val_d  = '0;
        out_last_d = name_last;
      end else begin
        out_kind_d = KIND_FIELD;
        out_char_d = '0;
        out_val_d  = fld_rdata_i;
        out_last_d = field_last;
      end
    end

    // transaction taken: advance the run or end it; the last field result also closes the line
    if ((state_q == ST_WAIT) && res_fire) begin
      out_valid_d = 1'b0;
      if (out_last_q) begin
        if (!run_name_q) begin
          count_d      = '0;
          name_taken_d = 1'b0;
          fcount_d     = '0;
        end
      end else begin
        idx_d = idx_q + IDX_W'(1);
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      name_taken_q <= 1'b0;
      fcount_q     <= '0;
      idx_q        <= '0;
      run_name_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      name_taken_q <= name_taken_d;
      fcount_q     <= fcount_d;
      idx_q        <= idx_d;
      run_name_q   <= run_name_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    out_kind_q <= out_kind_d;
    out_char_q <= out_char_d;
    out_val_q  <= out_val_d;
    out_pos_q  <= out_pos_d;
    out_last_q <= out_last_d;
  end

  // result channel
  assign res_o.valid       = out_valid_q;
  assign res_o.kind        = out_kind_q;
  assign res_o.name_char   = out_char_q;
  assign res_o.field_value = out_val_q;
  assign res_o.position    = out_pos_q;
  assign res_o.last        = out_last_q;

endmodule

// ===== hw/rtl/serial_command_line_parser.sv =====
// top level of the serial command line parser
`timescale 1ns / 1ps

// Parses lines of the form name:v1;v2\n one received byte per transaction.
// A byte that causes no result passes through intake and decode only; the
// block takes no new byte until every result of the current one has been
// delivered. Each name byte or field value passes through the registered read
// of the line or field store and then the single result register, where a
// stall on the result side can hold it. A line overflow is loaded into the
// result register straight from decode. No clearing pass is needed after reset.
module serial_command_line_parser import scl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  scl_rx_if.sink    rx_i,
  scl_res_if.source res_o
);

  field_cmd_t          field_cmd;
  logic [VAL_W-1:0]    field_value;
  logic                line_we;
  logic [LINE_AW-1:0]  line_waddr;
  logic [BYTE_W-1:0]   line_wdata;
  logic [LINE_AW-1:0]  line_raddr;
  logic [BYTE_W-1:0]   line_rdata;
  logic                fld_we;
  logic [FIELD_AW-1:0] fld_waddr;
  logic [FIELD_AW-1:0] fld_raddr;
  logic [VAL_W-1:0]    fld_rdata;

  // sequencer
  scl_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_i         (rx_i),
    .res_o        (res_o),
    .field_cmd_o  (field_cmd),
    .line_we_o    (line_we),
    .line_waddr_o (line_waddr),
    .line_wdata_o (line_wdata),
    .line_raddr_o (line_raddr),
    .line_rdata_i (line_rdata),
    .fld_we_o     (fld_we),
    .fld_waddr_o  (fld_waddr),
    .fld_raddr_o  (fld_raddr),
    .fld_rdata_i  (fld_rdata)
  );

  // field parser
  scl_field_unit u_field (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (field_cmd),
    .value_o (field_value)
  );

  // line buffer
  scl_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (LINE_BYTES)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (line_waddr),
    .wdata_i (line_wdata),
    .raddr_i (line_raddr),
    .rdata_o (line_rdata)
  );

  // closed field values
  scl_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_FIELDS)
  ) u_field_ram (
    .clk_i   (clk_i),
    .we_i    (fld_we),
    .waddr_i (fld_waddr),
    .wdata_i (field_value),
    .raddr_i (fld_raddr),
    .rdata_o (fld_rdata)
  );

  // intake and result delivery never overlap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rx_i.ready && res_o.valid))
    else $error("byte intake open while a result is pending");

  // an accepted byte is always decoded before the next one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_i.valid && rx_i.ready) |=> !rx_i.ready)
    else $error("byte accepted in back-to-back cycles");

  // overflow is a single result with no value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.kind == KIND_OVERFLOW)) |-> (res_o.last && (res_o.field_value == '0)))
    else $error("malformed overflow result");

  // within a run each result needs a fresh store read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.ready && !res_o.last) |=> !res_o.valid)
    else $error("result presented without a store read");

endmodule

// ===== tb/tb_serial_command_line_parser.sv =====
// testbench of the serial command line parser: directed and random lines checked against a local parse model
`timescale 1ns / 1ps

module tb_serial_command_line_parser;
  import scl_pkg::*;

  localparam int  RAND_BYTES  = 400;
  localparam int  HOLD_AT     = 80;
  localparam int  HOLD_CYCLES = 300;
  localparam int  SETTLE      = 8;
  localparam int  TAIL_CYCLES = 16;
  localparam int  MAX_PRINTS  = 50;
  localparam real LIMIT_NS    = 48.0e6;

  // one expected parser result
  typedef struct {
    kind_e                   kind;
    logic [BYTE_W-1:0]       ch;
    logic signed [VAL_W-1:0] val;
    logic [POS_W-1:0]        pos;
    logic                    last;
  } parse_res_t;

  // one entry of the byte feed: a byte, or a request to drain the parser
  typedef struct {
    bit                drain;
    logic [BYTE_W-1:0] b;
  } rx_item_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  scl_rx_if  rx_if ();
  scl_res_if res_if ();

  serial_command_line_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  always #6 clk_i = ~clk_i;

  rx_item_t   byte_feed[$];
  parse_res_t due_results[$];

  // model of the line parser
  logic [BYTE_W-1:0] line_buf [LINE_BYTES];
  logic [VAL_W-1:0]  field_vals [MAX_FIELDS];
  int                line_len;
  bit                name_fixed;
  int                n_fields;
  phase_e            phase;
  bit                negative;
  logic [VAL_W-1:0]  magnitude;

  // run bookkeeping
  int n_errors   = 0;
  int n_accepted = 0;
  int n_results  = 0;
  int n_names    = 0;
  int n_values   = 0;
  int n_overflow = 0;
  int n_lines    = 0;
  int n_pushed   = 0;

  // driver and monitor pacing
  int       gap_left, settle, wait_left, hold_left;
  bit       draining;
  int       tx_run = 0, rx_run = 0;
  bit       tx_calm = 1'b0, rx_calm = 1'b0;
  rx_item_t cur_item;
  parse_res_t want;

  logic [BYTE_W-1:0] ws_set [5] = '{CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};

  task automatic clear_field();
    phase     = PH_SKIP;
    negative  = 1'b0;
    magnitude = '0;
  endtask

  task automatic clear_line();
    line_len   = 0;
    name_fixed = 1'b0;
    n_fields   = 0;
    clear_field();
  endtask

  task automatic store_field();
    if (n_fields < MAX_FIELDS) begin
      field_vals[n_fields] = negative ? (32'd0 - magnitude) : magnitude;
      n_fields++;
    end
    clear_field();
  endtask

  // advance the parse model by one accepted byte and queue what it must emit
  task automatic parse_byte(input logic [BYTE_W-1:0] c);
    parse_res_t r;
    bit         digit, blank;
    if (line_len >= LINE_BYTES) begin
      r = '{kind: KIND_OVERFLOW, ch: '0, val: '0, pos: POS_W'(line_len), last: 1'b1};
      due_results.push_back(r);
      clear_line();
      return;
    end
    line_buf[line_len] = c;
    line_len++;
    // colon that fixes the command name
    if (c == CH_COLON && !name_fixed && line_len > 1) begin
      name_fixed = 1'b1;
      n_fields   = 0;
      clear_field();
      for (int i = 0; i + 1 < line_len; i++) begin
        r = '{kind: KIND_NAME, ch: line_buf[i], val: '0, pos: POS_W'(i),
              last: (i + 2 == line_len)};
        due_results.push_back(r);
      end
      return;
    end
    // field separators and end of line
    if (c == CH_SEMI || c == CH_COLON || c == CH_NL) begin
      store_field();
      if (c == CH_NL) begin
        for (int i = 0; i < n_fields; i++) begin
          r = '{kind: KIND_FIELD, ch: '0, val: field_vals[i], pos: POS_W'(i),
                last: (i + 1 == n_fields)};
          due_results.push_back(r);
        end
        clear_line();
      end
      return;
    end
    // atoi style field scan
    digit = (c >= CH_ZERO && c <= CH_NINE);
    blank = (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR);
    if (phase == PH_SKIP && blank) begin
    end else if (phase == PH_SKIP && (c == CH_PLUS || c == CH_MINUS)) begin
      negative = (c == CH_MINUS);
      phase    = PH_DIGITS;
    end else if (phase != PH_IGNORE && digit) begin
      magnitude = magnitude * 32'd10 + {24'd0, c - CH_ZERO};
      phase     = PH_DIGITS;
    end else begin
      phase = PH_IGNORE;
    end
  endtask

  // wait before the next transaction, with stretches of no waiting at all
  function automatic int draw_wait(inout int run_left, inout bit calm);
    if (run_left == 0) begin
      calm     = ~calm;
      run_left = $urandom_range(8, 60);
    end
    run_left--;
    return calm ? 0 : int'($urandom_range(0, 14));
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    if (n_errors < MAX_PRINTS)
      $display("mismatch at result %0d: %s got %0h wanted %0h", n_results, what, got,
               exp_val);
    n_errors++;
  endtask

  task automatic push_byte(input logic [BYTE_W-1:0] b);
    byte_feed.push_back('{drain: 1'b0, b: b});
    n_pushed++;
  endtask

  // random byte that is not a newline, a colon, and optionally not a semicolon
  function automatic logic [BYTE_W-1:0] pick_byte(input bit no_semi);
    logic [BYTE_W-1:0] b;
    do
      b = 8'($urandom_range(0, 255));
    while (b == CH_NL || b == CH_COLON || (no_semi && b == CH_SEMI));
    return b;
  endfunction

  // one field: blanks, sign, digits and maybe stray bytes
  task automatic add_field();
    int n;
    n = $urandom_range(0, 2);
    repeat (n) push_byte(ws_set[$urandom_range(0, 4)]);
    case ($urandom_range(0, 3))
      0: push_byte(CH_PLUS);
      1: push_byte(CH_MINUS);
      default: ;
    endcase
    if ($urandom_range(0, 9) == 0) push_byte(pick_byte(1'b1));
    n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 5);
    repeat (n) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
    if ($urandom_range(0, 5) == 0) push_byte(pick_byte(1'b1));
  endtask

  // byte driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_if.valid   <= 1'b0;
      rx_if.rx_byte <= '0;
      gap_left = 0;
      draining = 1'b0;
      settle   = 0;
    end else begin
      if (rx_if.valid && rx_if.ready) begin
        parse_byte(rx_if.rx_byte);
        n_accepted++;
      end
      if (!rx_if.valid || rx_if.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          rx_if.valid <= 1'b0;
        end else if (draining) begin
          // hold off until the parser has delivered everything and gone quiet
          rx_if.valid <= 1'b0;
          if (due_results.size() != 0) settle = 0;
          else if (settle < SETTLE) settle++;
          else draining = 1'b0;
        end else if (byte_feed.size() != 0) begin
          cur_item = byte_feed.pop_front();
          if (cur_item.drain) begin
            draining = 1'b1;
            settle   = 0;
            rx_if.valid <= 1'b0;
          end else begin
            rx_if.valid   <= 1'b1;
            rx_if.rx_byte <= cur_item.b;
            gap_left = draw_wait(tx_run, tx_calm);
          end
        end else begin
          rx_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      wait_left = 0;
      hold_left = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        n_results++;
        if (due_results.size() == 0) begin
          report_mismatch("result with nothing due, kind", 32'(res_if.kind), 32'hx);
        end else begin
          want = due_results.pop_front();
          if (res_if.kind !== want.kind)
            report_mismatch("kind", 32'(res_if.kind), 32'(want.kind));
          if (res_if.name_char !== want.ch)
            report_mismatch("name_char", 32'(res_if.name_char), 32'(want.ch));
          if (res_if.field_value !== want.val)
            report_mismatch("field_value", res_if.field_value, want.val);
          if (res_if.position !== want.pos)
            report_mismatch("position", 32'(res_if.position), 32'(want.pos));
          if (res_if.last !== want.last)
            report_mismatch("last", 32'(res_if.last), 32'(want.last));
          case (want.kind)
            KIND_NAME:  n_names++;
            KIND_FIELD: n_values++;
            default:    n_overflow++;
          endcase
        end
        wait_left = draw_wait(rx_run, rx_calm);
        if (n_results == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (wait_left != 0) begin
        wait_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // run limit
  initial begin
    #(LIMIT_NS);
    $display("timeout with %0d results still due", due_results.size());
    $display("tb_serial_command_line_parser: done, errors");
    $finish;
  end

  // stimulus and end of run
  initial begin
    logic [BYTE_W-1:0] directed [];
    int form, n, nf, start;
    bit mid_drain;

    directed = '{
      // colon at line start closes an empty field, no name
      CH_COLON, 8'h37, CH_NL,
      // one byte name, most negative value, sign and stop byte, later colon,
      // empty fields made of a 0xff byte and a nul byte
      8'h39, CH_COLON, CH_MINUS,
      8'h32, 8'h31, 8'h34, 8'h37, 8'h34, 8'h38, 8'h33, 8'h36, 8'h34, 8'h38,
      CH_SEMI, CH_TAB, CH_PLUS, 8'h35, 8'h78, CH_COLON, 8'hFF, CH_SEMI, 8'h00, CH_NL
    };
    mid_drain = 1'b0;

    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    res_if.ready  = 1'b0;
    rst_ni        = 1'b0;
    clear_line();

    foreach (directed[i]) push_byte(directed[i]);
    n_lines += 2;
    byte_feed.push_back('{drain: 1'b1, b: '0});

    // random lines, mostly well formed
    start = n_pushed;
    while (n_pushed - start < RAND_BYTES) begin
      if (n_lines == 2) form = 4;
      else if (n_lines == 3) form = 3;
      else begin
        n = $urandom_range(0, 99);
        form = (n < 62) ? 0 : (n < 80) ? 1 : (n < 92) ? 2 : (n < 96) ? 3 : 4;
      end
      case (form)
        0: begin
          // name, colon, fields, newline
          n = $urandom_range(1, 8);
          repeat (n) push_byte(pick_byte(1'b0));
          push_byte(CH_COLON);
          nf = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 11) : $urandom_range(0, 5);
          for (int f = 0; f < nf; f++) begin
            add_field();
            if (f + 1 < nf) push_byte(($urandom_range(0, 3) == 0) ? CH_COLON : CH_SEMI);
          end
          push_byte(CH_NL);
        end
        1: begin
          // no name, maybe a leading colon
          if ($urandom_range(0, 2) == 0) push_byte(CH_COLON);
          nf = $urandom_range(1, 4);
          for (int f = 0; f < nf; f++) begin
            add_field();
            if (f + 1 < nf) push_byte(CH_SEMI);
          end
          push_byte(CH_NL);
        end
        2: begin
          // raw noise
          n = $urandom_range(1, 20);
          repeat (n) push_byte(8'($urandom_range(0, 255)));
          push_byte(CH_NL);
        end
        3: begin
          // full line then one more byte, which is dropped
          repeat (LINE_BYTES) begin
            do n = $urandom_range(0, 255); while (n == CH_NL);
            push_byte(8'(n));
          end
          push_byte(8'($urandom_range(0, 255)));
        end
        default: begin
          // long name up to the longest run; at 63 bytes the newline overflows
          n = $urandom_range(56, LINE_BYTES - 1);
          repeat (n) push_byte(pick_byte(1'b0));
          push_byte(CH_COLON);
          push_byte(CH_NL);
        end
      endcase
      n_lines++;
      if (!mid_drain && n_pushed - start >= RAND_BYTES / 2) begin
        byte_feed.push_back('{drain: 1'b1, b: '0});
        mid_drain = 1'b1;
      end
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // wait for the feed to empty and every due result to arrive
    do @(posedge clk_i);
    while (byte_feed.size() != 0 || rx_if.valid || due_results.size() != 0 || draining);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (due_results.size() != 0)
      report_mismatch("results never delivered, count", 32'(due_results.size()), 32'd0);

    $display("fed %0d bytes in %0d lines, checked %0d results", n_accepted, n_lines,
             n_results);
    $display("  %0d name bytes, %0d field values, %0d line overflows, %0d mismatches",
             n_names, n_values, n_overflow, n_errors);
    if (n_errors == 0)
      $display("tb_serial_command_line_parser: done, clean");
    else
      $display("tb_serial_command_line_parser: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/scl_pkg.sv
hw/rtl/scl_stream_if.sv
hw/rtl/scl_ram.sv
hw/rtl/scl_field_unit.sv
hw/rtl/scl_ctrl.sv
hw/rtl/serial_command_line_parser.sv
tb/tb_serial_command_line_parser.sv
